[sv/rwabl_pkg.sv]
package rwabl_pkg;

    localparam int SAMPLE_W = 10;
    localparam int GAIN_W   = 5;
    localparam int STEP_W   = 12;
    localparam int MAG_W    = 15;
    localparam int MEAN_W   = 15;
    localparam int COUNT_W  = 3;
    localparam int MASK_W   = 4;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIDPOINT = 2'd0,
        REG_GAIN     = 2'd1,
        REG_BAR_STEP = 2'd2
    } cfg_reg_t;

    localparam logic [SAMPLE_W-1:0] MIDPOINT_RST = 10'd512;
    localparam logic [GAIN_W-1:0]   GAIN_RST     = 5'd17;
    localparam logic [STEP_W-1:0]   BAR_STEP_RST = 12'd254;

endpackage

[sv/rectified_window_average_bar_level_top.sv]
// Channel   Dir  Handshake                 Payload (low bit first)
// s_axis    in   s_tvalid / s_tready       s_tdata: sample[9:0], zero pad
// m_axis    out  m_tvalid / m_tready       m_tdata: mean_level, bar_count, lit_mask, pad
// cfg       in   cfg_valid / cfg_ready     cfg_index, cfg_data (cfg_ready always high)
//
// One beat per cycle sustained while m_tready is high; each beat passes through the sample,
// magnitude, sum, mean and output registers in turn. Sum loop: the running sum and ring write
// close together per beat; the ring read for the next slot is prefetched, so the ring memory port never stalls.
// Reset clears control, the sum and the fill flag; no clearing pass over the ring.
// Each stage holds when the one after it is full and stalled; bubbles still fill.
module rectified_window_average_bar_level_top #(
    parameter int WINDOW = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rwabl_pkg::S_TDATA_W-1:0]   s_tdata,   // [9:0] sample

    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rwabl_pkg::M_TDATA_W-1:0]   m_tdata,   // [14:0] mean_level, [17:15] bar_count,
                                                         // [21:18] lit_mask

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rwabl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rwabl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SAMPLE_W = rwabl_pkg::SAMPLE_W;
    localparam int GAIN_W   = rwabl_pkg::GAIN_W;
    localparam int STEP_W   = rwabl_pkg::STEP_W;
    localparam int MAG_W    = rwabl_pkg::MAG_W;
    localparam int MEAN_W   = rwabl_pkg::MEAN_W;
    localparam int COUNT_W  = rwabl_pkg::COUNT_W;
    localparam int MASK_W   = rwabl_pkg::MASK_W;

    localparam int IDX_W    = $clog2(WINDOW);
    localparam int SUM_W    = $clog2(WINDOW * (2 ** MAG_W - 1) + 1);
    // floor(sum / WINDOW) == (sum * RECIP) >> RECIP_SH for every SUM_W-bit sum
    localparam int RECIP_SH = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W  = SUM_W + 2;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SH) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    // configuration
    logic [SAMPLE_W-1:0] midpoint_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [STEP_W-1:0]   bar_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midpoint_reg <= rwabl_pkg::MIDPOINT_RST;
            gain_reg     <= rwabl_pkg::GAIN_RST;
            bar_step_reg <= rwabl_pkg::BAR_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rwabl_pkg::REG_MIDPOINT: midpoint_reg <= cfg_data[SAMPLE_W-1:0];
                rwabl_pkg::REG_GAIN:     gain_reg     <= cfg_data[GAIN_W-1:0];
                rwabl_pkg::REG_BAR_STEP: bar_step_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and stall chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // stage payloads
    logic [SAMPLE_W-1:0] sample_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic [MEAN_W-1:0]   mean_out_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [MASK_W-1:0]   mask_reg;

    // ring bookkeeping
    logic [IDX_W-1:0]    widx_reg;
    logic [IDX_W-1:0]    widx_next;
    logic                wrapped_reg;
    logic                wrapped_next;
    logic [MAG_W-1:0]    rd_data_reg;
    logic [MAG_W-1:0]    ring [WINDOW];

    logic                upd;
    logic [SAMPLE_W-1:0] diff;
    logic [MAG_W-1:0]    mag_next;
    logic [MAG_W-1:0]    old_mag;
    logic [SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   mean_wide;
    logic [MEAN_W-1:0]   step1, step2, step3, step4;
    logic [MASK_W-1:0]   mask_next;
    logic [COUNT_W-1:0]  count_next;

    always_comb
    begin
        diff = (sample_reg >= midpoint_reg) ? (sample_reg - midpoint_reg)
                                            : (midpoint_reg - sample_reg);
        mag_next = MAG_W'(diff) * MAG_W'(gain_reg);
    end

    // sum update happens as an item leaves the magnitude stage
    assign upd = v2_reg && rdy3;

    always_comb
    begin
        widx_next    = widx_reg;
        wrapped_next = wrapped_reg;
        if (upd)
        begin
            if (widx_reg == LAST_IDX)
            begin
                widx_next    = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                widx_next = widx_reg + 1'b1;
            end
        end
    end

    // a slot not yet written since reset reads as zero; slots fill in order
    assign old_mag  = wrapped_reg ? rd_data_reg : '0;
    assign sum_next = sum_reg - SUM_W'(old_mag) + SUM_W'(mag_reg);

    assign prod      = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign mean_wide = prod >> RECIP_SH;

    always_comb
    begin
        step1 = MEAN_W'(bar_step_reg);
        step2 = MEAN_W'(bar_step_reg) << 1;
        step3 = step2 + step1;
        step4 = MEAN_W'(bar_step_reg) << 2;
        // a zero step lights every digit on its own
        mask_next[0] = (mean_reg >= step1);
        mask_next[1] = (mean_reg >= step2);
        mask_next[2] = (mean_reg >= step3);
        mask_next[3] = (mean_reg >= step4);
        count_next = COUNT_W'(mask_next[0]) + COUNT_W'(mask_next[1])
                   + COUNT_W'(mask_next[2]) + COUNT_W'(mask_next[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            sum_reg     <= '0;
            widx_reg    <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
            if (upd)
                sum_reg <= sum_next;
            widx_reg    <= widx_next;
            wrapped_reg <= wrapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        if (rdy2 && v1_reg)
            mag_reg <= mag_next;
        if (rdy4 && v3_reg)
            mean_reg <= mean_wide[MEAN_W-1:0];
        if (rdy5 && v4_reg)
        begin
            mean_out_reg <= mean_reg;
            count_reg    <= count_next;
            mask_reg     <= mask_next;
        end
    end

    // ring memory: write the current slot, prefetch the slot the next beat replaces
    always_ff @(posedge clk)
    begin
        if (upd)
            ring[widx_reg] <= mag_reg;
        rd_data_reg <= ring[widx_next];
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {{(rwabl_pkg::M_TDATA_W - MEAN_W - COUNT_W - MASK_W){1'b0}},
                       mask_reg, count_reg, mean_out_reg};

    ap_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (widx_reg == $past(widx_reg) + 1'b1) || (widx_reg == '0))
        else $error("ring index did not advance by one");

    ap_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(wrapped_reg))
        else $error("fill flag dropped");

    ap_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> ((mean_wide >> MEAN_W) == '0))
        else $error("mean does not fit its field");

    ap_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> ($countones(mask_reg) == int'(count_reg)))
        else $error("bar count and mask disagree");

    ap_idle_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(sum_reg))
        else $error("sum changed without a beat");

endmodule

[tb/testbench.sv]
module testbench;

    localparam int SAMPLE_W    = rwabl_pkg::SAMPLE_W;
    localparam int GAIN_W      = rwabl_pkg::GAIN_W;
    localparam int STEP_W      = rwabl_pkg::STEP_W;
    localparam int MAG_W       = rwabl_pkg::MAG_W;
    localparam int MEAN_W      = rwabl_pkg::MEAN_W;
    localparam int COUNT_W     = rwabl_pkg::COUNT_W;
    localparam int MASK_W      = rwabl_pkg::MASK_W;
    localparam int S_TDATA_W   = rwabl_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = rwabl_pkg::M_TDATA_W;
    localparam int CFG_INDEX_W = rwabl_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = rwabl_pkg::CFG_DATA_W;

    localparam int WIN        = 50;
    localparam int CYCLE_CAP  = 400000;
    localparam int SHOW_MAX   = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] bars;
        logic [MEAN_W-1:0]  mean;
    } level_beat_t;

    typedef enum int {SEG_QUIET, SEG_SPREAD, SEG_RAIL} seg_kind_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // predictor state
    logic [MAG_W-1:0]    ring_mag [WIN];
    int unsigned         ring_pos;
    logic [20:0]         mag_sum;
    logic [SAMPLE_W-1:0] mid_r;
    logic [GAIN_W-1:0]   gain_r;
    logic [STEP_W-1:0]   step_r;

    logic [SAMPLE_W-1:0] sample_q [$];
    level_beat_t         level_q [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cfg_beats      = 0;
    int unsigned errors         = 0;
    int unsigned cycles         = 0;

    rectified_window_average_bar_level_top #(.WINDOW(WIN)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int k = 0; k < WIN; k++)
            ring_mag[k] = '0;
        ring_pos = 0;
        mag_sum  = '0;
        mid_r    = rwabl_pkg::MIDPOINT_RST;
        gain_r   = rwabl_pkg::GAIN_RST;
        step_r   = rwabl_pkg::BAR_STEP_RST;
    end

    // Rectify, push into the window and return the meter reading.
    function automatic level_beat_t advance_meter(input logic [SAMPLE_W-1:0] smp);
        logic [SAMPLE_W-1:0] delta;
        logic [MAG_W-1:0]    mag;
        int unsigned         lvl;
        level_beat_t         r;
        delta = (smp >= mid_r) ? smp - mid_r : mid_r - smp;
        mag = MAG_W'(delta) * MAG_W'(gain_r);
        mag_sum = mag_sum - ring_mag[ring_pos] + mag;
        ring_mag[ring_pos] = mag;
        ring_pos = (ring_pos + 1) % WIN;
        r.mean = MEAN_W'(mag_sum / WIN);
        if (step_r == 0)
            lvl = 4;
        else
        begin
            lvl = r.mean / step_r;
            if (lvl > 4)
                lvl = 4;
        end
        r.bars = COUNT_W'(lvl);
        r.mask = MASK_W'((1 << lvl) - 1);
        return r;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                level_q.push_back(advance_meter(s_tdata[SAMPLE_W-1:0]));
            if (!s_tvalid || s_tready)
            begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(sample_q.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // register writes land in the predictor on the handshake
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rwabl_pkg::REG_MIDPOINT: mid_r  = cfg_data[SAMPLE_W-1:0];
                rwabl_pkg::REG_GAIN:     gain_r = cfg_data[GAIN_W-1:0];
                rwabl_pkg::REG_BAR_STEP: step_r = cfg_data[STEP_W-1:0];
                default: ;
            endcase
            cfg_beats++;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        level_beat_t got, want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = level_beat_t'(m_tdata[MASK_W+COUNT_W+MEAN_W-1:0]);
                if (level_q.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display("unexpected beat: mean %0d bars %0d mask %b",
                                 got.mean, got.bars, got.mask);
                end
                else
                begin
                    want = level_q.pop_front();
                    if (got.mean !== want.mean || got.bars !== want.bars ||
                        got.mask !== want.mask)
                    begin
                        errors++;
                        if (errors <= SHOW_MAX)
                            $display("mismatch: mean %0d/%0d bars %0d/%0d mask %b/%b (exp/got)",
                                     want.mean, got.mean, want.bars, got.bars,
                                     want.mask, got.mask);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("rectified_window_average_bar_level_top verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int unsigned seen;
        seen = cfg_beats;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        wait (cfg_beats != seen);
        cfg_valid <= 1'b0;
    endtask

    // blocks until nothing is in flight
    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || level_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_noise(input int n);
        int        left;
        int        seg;
        int        lo;
        int        hi;
        seg_kind_t kind;
        left = n;
        while (left > 0)
        begin
            seg = $urandom_range(5, 30);
            if (seg > left)
                seg = left;
            kind = seg_kind_t'($urandom_range(2));
            for (int k = 0; k < seg; k++)
            begin
                case (kind)
                    SEG_QUIET:
                    begin
                        lo = int'(mid_r) - 40;
                        hi = int'(mid_r) + 40;
                        if (lo < 0)
                            lo = 0;
                        if (hi > 1023)
                            hi = 1023;
                        sample_q.push_back(SAMPLE_W'($urandom_range(hi, lo)));
                    end
                    SEG_SPREAD: sample_q.push_back(SAMPLE_W'($urandom_range(1023)));
                    default:    sample_q.push_back($urandom_range(1) ? 10'h3FF : 10'h000);
                endcase
            end
            left -= seg;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings, directed corners first
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sample_q = '{10'h000, 10'h3FF, 10'h200, 10'h1FF, 10'h201, 10'h155, 10'h2AA,
                     10'h001, 10'h3FE, 10'h3FF, 10'h000, 10'h3FF, 10'h000, 10'h3FF,
                     10'h000, 10'h3FF, 10'h000, 10'h3FF, 10'h000, 10'h200};
        queue_noise(60);
        wait_drained();

        // unused index is dropped; over-wide data gets masked
        write_reg(REG_UNUSED, 12'hABC);
        write_reg(rwabl_pkg::REG_MIDPOINT, 12'hFFF);
        write_reg(rwabl_pkg::REG_GAIN, 12'hFFF);
        write_reg(rwabl_pkg::REG_BAR_STEP, 12'hFFF);
        send_idle_pct = 45;
        queue_noise(80);
        wait_drained();

        // full-scale window, zero step saturates
        write_reg(rwabl_pkg::REG_MIDPOINT, 12'h000);
        write_reg(rwabl_pkg::REG_GAIN, 12'd31);
        write_reg(rwabl_pkg::REG_BAR_STEP, 12'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        repeat (60) sample_q.push_back(10'h3FF);
        repeat (20) sample_q.push_back(10'h000);
        queue_noise(30);
        wait_drained();

        write_reg(rwabl_pkg::REG_MIDPOINT, 12'hE00);
        write_reg(rwabl_pkg::REG_GAIN, 12'h000);
        write_reg(rwabl_pkg::REG_BAR_STEP, 12'd1);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        queue_noise(30);
        wait_drained();
        write_reg(rwabl_pkg::REG_GAIN, 12'd1);
        queue_noise(60);
        wait_drained();

        write_reg(rwabl_pkg::REG_MIDPOINT, CFG_DATA_W'($urandom));
        write_reg(rwabl_pkg::REG_GAIN, {7'($urandom), 5'($urandom_range(31, 1))});
        write_reg(rwabl_pkg::REG_BAR_STEP, CFG_DATA_W'($urandom_range(1500, 200)));
        queue_noise(40);
        // sender holds off until the pipe is empty, then resumes
        wait_drained();
        queue_noise(40);
        wait_drained();

        write_reg(rwabl_pkg::REG_MIDPOINT, 12'(rwabl_pkg::MIDPOINT_RST));
        write_reg(rwabl_pkg::REG_GAIN, 12'(rwabl_pkg::GAIN_RST));
        write_reg(rwabl_pkg::REG_BAR_STEP, rwabl_pkg::BAR_STEP_RST);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_noise(30);
        wait_drained();
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("rectified_window_average_bar_level_top verification clean");
        else
            $display("rectified_window_average_bar_level_top verification failed");
        $finish;
    end

endmodule

[files.f]
sv/rwabl_pkg.sv
sv/rectified_window_average_bar_level_top.sv
tb/testbench.sv
